FILE: sv/brfc_pkg.sv
// Shared constants, types and helpers of the binary region feature counter.
`timescale 1ns / 1ps
package brfc_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 128;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CFG_W   = 9;
  localparam int CNT_W   = 16;
  localparam int CSUM_W  = 23;
  localparam int RSUM_W  = 22;
  localparam int EACC_W  = 19;
  localparam int EUL_W   = 16;

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(MAX_WIDTH);

  typedef struct packed {
    logic             beat;
    logic             clear;
    logic [COL_W-1:0] wr_col;
    logic             wr_bit;
    logic [COL_W-1:0] rd_col;
  } lb_req_t;

  typedef struct packed {
    logic        [CNT_W-1:0]  area;
    logic        [CSUM_W-1:0] column_sum;
    logic        [RSUM_W-1:0] row_sum;
    logic        [CNT_W-1:0]  perimeter;
    logic        [CNT_W-1:0]  quad_one;
    logic        [CNT_W-1:0]  quad_three;
    logic        [CNT_W-1:0]  quad_diagonal;
    logic signed [EACC_W-1:0] euler_raw;
  } res_t;

endpackage

FILE: sv/brfc_if.sv
// Handshake interfaces for the pixel, configuration and result channels.
`timescale 1ns / 1ps
interface brfc_pix_if import brfc_pkg::*; ();
  logic valid;
  logic ready;
  logic pixel;
  logic last_pixel;
  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

interface brfc_cfg_if import brfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_width;
  modport source (output valid, output window_width, input ready);
  modport sink (input valid, input window_width, output ready);
endinterface

interface brfc_res_if import brfc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [CNT_W-1:0]  area;
  logic        [CSUM_W-1:0] column_sum;
  logic        [RSUM_W-1:0] row_sum;
  logic        [CNT_W-1:0]  perimeter;
  logic        [CNT_W-1:0]  quad_one;
  logic        [CNT_W-1:0]  quad_three;
  logic        [CNT_W-1:0]  quad_diagonal;
  logic signed [EUL_W-1:0]  euler_number;
  modport source (output valid, output area, output column_sum, output row_sum,
                  output perimeter, output quad_one, output quad_three,
                  output quad_diagonal, output euler_number, input ready);
  modport sink (input valid, input area, input column_sum, input row_sum,
                input perimeter, input quad_one, input quad_three,
                input quad_diagonal, input euler_number, output ready);
endinterface

FILE: sv/brfc_line_buf.sv
// Row-above line buffer: synchronous bit memory with per-entry valid flags and pre-read.
`timescale 1ns / 1ps
module brfc_line_buf import brfc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  lb_req_t req_i,
  output logic    up_o
);

  logic                 mem [MAX_WIDTH];
  logic                 rdat_q;
  logic [MAX_WIDTH-1:0] vld_q;
  logic                 rvld_q;
  logic                 byp_q;
  logic                 bypv_q;

  always_ff @(posedge clk_i) begin
    if (req_i.beat) begin
      mem[req_i.wr_col] <= req_i.wr_bit;
      rdat_q            <= mem[req_i.rd_col];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      byp_q  <= 1'b0;
      bypv_q <= 1'b0;
    end else if (req_i.beat) begin
      if (req_i.clear) begin
        vld_q  <= '0;
        rvld_q <= 1'b0;
        byp_q  <= 1'b0;
      end else begin
        vld_q[req_i.wr_col] <= 1'b1;
        rvld_q              <= vld_q[req_i.rd_col];
        byp_q               <= (req_i.rd_col == req_i.wr_col);
        bypv_q              <= req_i.wr_bit;
      end
    end
  end

  // single-column rows read back the bit written on the same beat
  assign up_o = byp_q ? bypv_q : (rvld_q & rdat_q);

endmodule

FILE: sv/brfc_accum.sv
// Per-pixel quad classification, position tracking and saturating feature counters.
`timescale 1ns / 1ps
module brfc_accum import brfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic             pixel_i,
  input  logic             last_i,
  input  logic [CFG_W-1:0] width_i,
  input  logic             up_i,
  output lb_req_t          lb_req_o,
  output res_t             res_o
);

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [CSUM_W-1:0] CSUM_MAX = '1;
  localparam logic [RSUM_W-1:0] RSUM_MAX = '1;
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             left_q, ul_q;
  res_t             cnt_q, cnt_d;

  logic [CFG_W-1:0]   eff_w;
  logic               eor;
  logic [2:0]         qsum;
  logic               q1_inc, q3_inc, qd_inc;
  logic [CSUM_W:0]    csum_x;
  logic [RSUM_W:0]    rsum_x;
  logic [CNT_W:0]     edge_x;
  logic [1:0]         edge_inc;
  logic signed [EACC_W-1:0] e_delta;

  always_comb begin
    eff_w = (width_i == '0 || width_i > WIDTH_RESET) ? WIDTH_RESET : width_i;
    eor   = (CFG_W'(col_q) + CFG_W'(1)) >= eff_w;
    col_d = eor ? '0 : col_q + COL_W'(1);
    row_d = (eor && row_q != ROW_LAST) ? row_q + ROW_W'(1) : row_q;

    qsum   = 3'(pixel_i) + 3'(up_i) + 3'(ul_q) + 3'(left_q);
    q1_inc = (qsum == 3'd1) && (cnt_q.quad_one != CNT_MAX);
    q3_inc = (qsum == 3'd3) && (cnt_q.quad_three != CNT_MAX);
    qd_inc = (qsum == 3'd2) && ((pixel_i && ul_q) || (up_i && left_q))
             && (cnt_q.quad_diagonal != CNT_MAX);

    priority if (q1_inc) e_delta = EACC_W'(1);
    else if (q3_inc)     e_delta = -EACC_W'(1);
    else if (qd_inc)     e_delta = -EACC_W'(2);
    else                 e_delta = '0;

    csum_x   = {1'b0, cnt_q.column_sum} + (CSUM_W + 1)'(col_q);
    rsum_x   = {1'b0, cnt_q.row_sum} + (RSUM_W + 1)'(row_q);
    edge_inc = 2'(pixel_i ^ left_q) + 2'(pixel_i ^ up_i);
    edge_x   = {1'b0, cnt_q.perimeter} + (CNT_W + 1)'(edge_inc);

    cnt_d = cnt_q;
    if (q1_inc) cnt_d.quad_one      = cnt_q.quad_one + CNT_W'(1);
    if (q3_inc) cnt_d.quad_three    = cnt_q.quad_three + CNT_W'(1);
    if (qd_inc) cnt_d.quad_diagonal = cnt_q.quad_diagonal + CNT_W'(1);
    cnt_d.euler_raw = cnt_q.euler_raw + e_delta;
    if (pixel_i) begin
      if (cnt_q.area != CNT_MAX) cnt_d.area = cnt_q.area + CNT_W'(1);
      cnt_d.column_sum = csum_x[CSUM_W] ? CSUM_MAX : csum_x[CSUM_W-1:0];
      cnt_d.row_sum    = rsum_x[RSUM_W] ? RSUM_MAX : rsum_x[RSUM_W-1:0];
    end
    cnt_d.perimeter = edge_x[CNT_W] ? CNT_MAX : edge_x[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= 1'b0;
      ul_q   <= 1'b0;
      cnt_q  <= '0;
    end else if (beat_i) begin
      if (last_i) begin
        col_q  <= '0;
        row_q  <= '0;
        left_q <= 1'b0;
        ul_q   <= 1'b0;
        cnt_q  <= '0;
      end else begin
        col_q  <= col_d;
        row_q  <= row_d;
        left_q <= eor ? 1'b0 : pixel_i;
        ul_q   <= eor ? 1'b0 : up_i;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_comb begin
    lb_req_o.beat   = beat_i;
    lb_req_o.clear  = last_i;
    lb_req_o.wr_col = col_q;
    lb_req_o.wr_bit = pixel_i;
    lb_req_o.rd_col = col_d;
  end

  assign res_o = cnt_d;

endmodule

FILE: sv/brfc_out_q.sv
// Two-entry result queue: output register plus skid slot.
`timescale 1ns / 1ps
module brfc_out_q import brfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  output logic vld_o,
  input  logic rdy_i,
  output res_t data_o
);

  logic s0v_q, s1v_q;
  res_t s0_q, s1_q;
  logic pop;

  assign pop = s0v_q && rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0v_q <= 1'b0;
      s1v_q <= 1'b0;
    end else if (pop) begin
      if (!s1v_q) s0v_q <= push_i;
      else        s1v_q <= push_i;
    end else if (push_i) begin
      if (!s0v_q) s0v_q <= 1'b1;
      else        s1v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (s1v_q) begin
        s0_q <= s1_q;
        if (push_i) s1_q <= data_i;
      end else if (push_i) begin
        s0_q <= data_i;
      end
    end else if (push_i) begin
      if (!s0v_q) s0_q <= data_i;
      else        s1_q <= data_i;
    end
  end

  assign full_o = s1v_q;
  assign vld_o  = s0v_q;
  assign data_o = s0_q;

endmodule

FILE: sv/binary_region_feature_counter.sv
// Binary region feature counter top level: 2x2 bit-quad counts and Euler number per window.
// Usage:
//   pix_i carries one binary pixel per beat in raster order over a window that has a
//   one-pixel background border; last_pixel marks the final pixel of the window.
//   cfg_i writes window_width (padded columns per row); it is always ready and is
//   meant to be written between windows. Reset value is 256.
//   res_o carries one result beat per window: area, coordinate sums, perimeter,
//   the three quad counts and the 8-connected Euler number.
// Throughput: one pixel per cycle while pix_i.ready is high. The row above each pixel comes from a
//   synchronous line memory that is read ahead, at the next column, on each beat.
// Result: each window's result enters the output queue on the beat carrying last_pixel.
// Reset: all counters, position and line-buffer valid flags clear at once; there is
//   no clearing pass, so pixels are accepted as soon as reset is released. The same
//   clear happens after every last pixel.
// Stall: results queue in two entries; pix_i.ready drops only while both are held.
`timescale 1ns / 1ps
module binary_region_feature_counter import brfc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  brfc_pix_if.sink       pix_i,
  brfc_cfg_if.sink       cfg_i,
  brfc_res_if.source     res_o
);

  logic [CFG_W-1:0] width_q;
  logic             beat;
  logic             full;
  logic             up;
  lb_req_t          lb_req;
  res_t             res_new;
  res_t             res_head;

  logic signed [EACC_W-1:0] e_adj;
  logic signed [EACC_W-1:0] e_quo;

  localparam logic signed [EACC_W-1:0] EUL_MIN = EACC_W'(-(2 ** (EUL_W - 1)));

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_i.valid) begin
      width_q <= cfg_i.window_width;
    end
  end

  assign pix_i.ready = !full;
  assign beat        = pix_i.valid && !full;

  brfc_line_buf u_line_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lb_req),
    .up_o   (up)
  );

  brfc_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat),
    .pixel_i  (pix_i.pixel),
    .last_i   (pix_i.last_pixel),
    .width_i  (width_q),
    .up_i     (up),
    .lb_req_o (lb_req),
    .res_o    (res_new)
  );

  brfc_out_q u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (beat && pix_i.last_pixel),
    .data_i (res_new),
    .full_o (full),
    .vld_o  (res_o.valid),
    .rdy_i  (res_o.ready),
    .data_o (res_head)
  );

  // divide by four, rounding toward zero, then clamp at the low end of the signed output range
  always_comb begin
    e_adj = res_head.euler_raw[EACC_W-1] ? res_head.euler_raw + EACC_W'(3)
                                         : res_head.euler_raw;
    e_quo = e_adj >>> 2;
    res_o.euler_number = (e_quo < EUL_MIN) ? EUL_MIN[EUL_W-1:0] : e_quo[EUL_W-1:0];
  end

  assign res_o.area          = res_head.area;
  assign res_o.column_sum    = res_head.column_sum;
  assign res_o.row_sum       = res_head.row_sum;
  assign res_o.perimeter     = res_head.perimeter;
  assign res_o.quad_one      = res_head.quad_one;
  assign res_o.quad_three    = res_head.quad_three;
  assign res_o.quad_diagonal = res_head.quad_diagonal;

endmodule

FILE: sv/brfc_checker.sv
// Port-level checker for the binary region feature counter and its bind.
`timescale 1ns / 1ps
module brfc_checker import brfc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pix_valid_i,
  input logic              pix_ready_i,
  input logic              pix_last_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [CNT_W-1:0]  area_i,
  input logic [CSUM_W-1:0] column_sum_i,
  input logic [RSUM_W-1:0] row_sum_i,
  input logic [CNT_W-1:0]  perimeter_i,
  input logic [EUL_W-1:0]  euler_i
);

  a_res_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(pix_valid_i && pix_ready_i && pix_last_i))
    else $error("result beat without a preceding last pixel");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_ready_i |-> res_valid_i)
    else $error("pixel channel stalled with no pending result");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && area_i == '0) |->
      (column_sum_i == '0 && row_sum_i == '0 && perimeter_i == '0))
    else $error("empty window reports nonzero sums");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(area_i) && $stable(euler_i)))
    else $error("stalled result beat changed");

endmodule

bind binary_region_feature_counter brfc_checker u_brfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pix_valid_i  (pix_i.valid),
  .pix_ready_i  (pix_i.ready),
  .pix_last_i   (pix_i.last_pixel),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .area_i       (res_o.area),
  .column_sum_i (res_o.column_sum),
  .row_sum_i    (res_o.row_sum),
  .perimeter_i  (res_o.perimeter),
  .euler_i      (res_o.euler_number)
);
